@@ rtl/core/jdd_pkg.sv @@
// ----------------------------------------------------------------------------
// jdd_pkg
// Shared types and codes for the joystick direction debounce block.
// ----------------------------------------------------------------------------
package jdd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd3;

  // layer modes
  localparam logic [1:0] MODE_KEY = 2'd0;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam int unsigned DEB_BITS = 8;

  // direction lane indexes
  localparam int unsigned DIR_RIGHT = 0;
  localparam int unsigned DIR_LEFT  = 1;
  localparam int unsigned DIR_UP    = 2;
  localparam int unsigned DIR_DOWN  = 3;
  localparam int unsigned NUM_DIRS  = 4;

  typedef struct packed {
    logic pos;
    logic neg;
  } axis_t;

  typedef struct packed {
    logic       active;
    logic [1:0] evt;
  } dir_t;

endpackage

@@ rtl/core/jdd_axis.sv @@
// ----------------------------------------------------------------------------
// jdd_axis
// One axis lane: center offset, dead zone and threshold compare.
// ----------------------------------------------------------------------------
module jdd_axis
  import jdd_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic [ADC_BITS-1:0] sample,
  input  logic [ADC_BITS-1:0] center_value,
  input  logic [ADC_BITS-1:0] trigger_threshold,
  input  logic [ADC_BITS-1:0] dead_zone,
  output axis_t               dir
);

  logic [ADC_BITS:0]   offset;
  logic                below;
  logic [ADC_BITS-1:0] mag;
  logic                zeroed;
  logic                beyond;

  always_comb begin
    offset = {1'b0, sample} - {1'b0, center_value};
    below  = offset[ADC_BITS];
    // magnitude always fits in ADC_BITS bits
    mag    = below ? ADC_BITS'(-offset) : offset[ADC_BITS-1:0];
    zeroed = mag < dead_zone;
    beyond = !zeroed && (mag > trigger_threshold);
    dir.pos = beyond && !below;
    dir.neg = beyond && below;
  end

endmodule

@@ rtl/core/jdd_debounce.sv @@
// ----------------------------------------------------------------------------
// jdd_debounce
// One direction lane: stable bit, mismatch counter and event code.
// ----------------------------------------------------------------------------
module jdd_debounce
  import jdd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                raw,
  input  logic                key_mode,
  input  logic [DEB_BITS-1:0] debounce_limit,
  output dir_t                dir
);

  logic                stable;
  logic                stable_next;
  logic [DEB_BITS-1:0] count;
  logic [DEB_BITS-1:0] count_next;
  logic [1:0]          evt;

  always_comb begin
    stable_next = stable;
    count_next  = '0;
    evt         = EV_NONE;
    if (raw != stable) begin
      if (count < debounce_limit) begin
        count_next = count + 1'b1;
      end else begin
        stable_next = raw;
        if (key_mode) begin
          evt = raw ? EV_PRESS : EV_RELEASE;
        end
      end
    end
    dir.active = stable_next;
    dir.evt    = evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      count  <= '0;
    end else if (advance) begin
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

@@ rtl/core/joystick_direction_debounce.sv @@
// ----------------------------------------------------------------------------
// joystick_direction_debounce
// Analog joystick to four-direction pad with dead zone and debounce.
//
// Input channel (in_valid/in_ready) carries one scan word: x_sample,
// y_sample and layer_mode. Output channel (out_valid/out_ready) returns one
// word per scan: the debounced right/left/up/down state and a press or
// release event per direction (events only in key mode).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written by the user only while the block is idle (the block does not
// enforce it); index 0 center, 1 trigger threshold, 2 dead zone, 3
// debounce limit (low 8 bits). Two register stages: stage 1 holds the scan,
// stage 2 the result. Throughput: one scan per clock while the receiver
// takes words; two axis lanes classify in stage 1, four debounce lanes
// update their state and the merged result is registered in stage 2.
// Reset clears the direction state and counters and loads the default
// registers. When the receiver stalls the output word holds and the
// pipeline fills; in_ready drops only once both stages are full.
// ----------------------------------------------------------------------------
module joystick_direction_debounce
  import jdd_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] x_sample,
  input  logic [ADC_BITS-1:0] y_sample,
  input  logic [1:0]          layer_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                right_active,
  output logic                left_active,
  output logic                up_active,
  output logic                down_active,
  output logic [1:0]          right_event,
  output logic [1:0]          left_event,
  output logic [1:0]          up_event,
  output logic [1:0]          down_event,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [ADC_BITS-1:0] cfg_data
);

  logic [ADC_BITS-1:0] center_value;
  logic [ADC_BITS-1:0] trigger_threshold;
  logic [ADC_BITS-1:0] dead_zone;
  logic [DEB_BITS-1:0] debounce_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_value      <= ADC_BITS'(512);
      trigger_threshold <= ADC_BITS'(200);
      dead_zone         <= ADC_BITS'(50);
      debounce_limit    <= DEB_BITS'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER:    center_value      <= cfg_data;
        REG_THRESHOLD: trigger_threshold <= cfg_data;
        REG_DEAD_ZONE: dead_zone         <= cfg_data;
        REG_DEBOUNCE:  debounce_limit    <= cfg_data[DEB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: axis lanes
  axis_t x_dir;
  axis_t y_dir;

  jdd_axis #(.ADC_BITS(ADC_BITS)) u_axis_x (
    .sample            (x_sample),
    .center_value      (center_value),
    .trigger_threshold (trigger_threshold),
    .dead_zone         (dead_zone),
    .dir               (x_dir)
  );

  jdd_axis #(.ADC_BITS(ADC_BITS)) u_axis_y (
    .sample            (y_sample),
    .center_value      (center_value),
    .trigger_threshold (trigger_threshold),
    .dead_zone         (dead_zone),
    .dir               (y_dir)
  );

  logic                s1_valid;
  logic [NUM_DIRS-1:0] s1_raw;
  logic                s1_key;
  logic                s2_advance;
  logic                in_take;

  assign s2_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s2_advance;
  assign in_take    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw[DIR_RIGHT] <= x_dir.pos;
      s1_raw[DIR_LEFT]  <= x_dir.neg;
      s1_raw[DIR_UP]    <= y_dir.neg;
      s1_raw[DIR_DOWN]  <= y_dir.pos;
      s1_key            <= (layer_mode == MODE_KEY);
    end
  end

  // stage 2: debounce lanes
  dir_t dirs [NUM_DIRS];

  for (genvar d = 0; d < NUM_DIRS; d++) begin : g_lane
    jdd_debounce u_lane (
      .clk            (clk),
      .rst            (rst),
      .advance        (s2_advance),
      .raw            (s1_raw[d]),
      .key_mode       (s1_key),
      .debounce_limit (debounce_limit),
      .dir            (dirs[d])
    );
  end

  // merge into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance) begin
      right_active <= dirs[DIR_RIGHT].active;
      left_active  <= dirs[DIR_LEFT].active;
      up_active    <= dirs[DIR_UP].active;
      down_active  <= dirs[DIR_DOWN].active;
      right_event  <= dirs[DIR_RIGHT].evt;
      left_event   <= dirs[DIR_LEFT].evt;
      up_event     <= dirs[DIR_UP].evt;
      down_event   <= dirs[DIR_DOWN].evt;
    end
  end

endmodule
